[src/npss_pkg.sv]
package npss_pkg;

	// Search limits
	localparam int unsigned MAX_LANES = 256;
	localparam int unsigned MAX_KEYS = 256;
	localparam logic signed [33:0] BOX_LIMIT = 34'sd998400;
	localparam logic [20:0] DIST_MAX = 21'h1FFFFF;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TARGET_X = 2'd0,
		CFG_TARGET_Y = 2'd1,
		CFG_TARGET_Z = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic signed [31:0] seg_start_x;
		logic signed [31:0] seg_start_y;
		logic signed [31:0] seg_start_z;
		logic signed [31:0] seg_delta_x;
		logic signed [31:0] seg_delta_y;
		logic signed [31:0] seg_delta_z;
		logic [7:0] lane_number;
		logic [7:0] key_number;
		logic first_segment;
		logic last_segment;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [20:0] best_distance;
		logic [7:0] best_lane;
		logic [7:0] best_key;
		logic signed [31:0] near_x;
		logic signed [31:0] near_y;
		logic signed [31:0] near_z;
	} out_item_t;

	// Request to the shared divide / square-root unit
	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} rd_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rd_stat_t;

endpackage

[src/npss_root_div.sv]
module npss_root_div import npss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  rd_req_t req,
	input  logic [63:0] opa,
	input  logic [63:0] opb,
	output rd_stat_t stat,
	output logic [31:0] result
);

	logic [64:0] x_q;
	logic [63:0] den_q;
	logic [63:0] acc_q;
	logic [63:0] bit_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic mode_q;

	logic [64:0] xin;
	logic [64:0] yin;
	logic [65:0] diff;
	logic ge;
	logic last_step;

	// Shared subtract and compare: remainder step or root step
	always_comb begin
		if (mode_q) begin
			xin = x_q;
			yin = {1'b0, acc_q} + {1'b0, bit_q};
		end else begin
			xin = {x_q[63:0], 1'b0};
			yin = {1'b0, den_q};
		end
		diff = {1'b0, xin} - {1'b0, yin};
		ge = ~diff[65];
		last_step = mode_q ? (cnt_q == 5'd31) : (cnt_q == 5'd15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mode_q <= req.sqrt_mode;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= {1'b0, opa};
			den_q <= opb;
			acc_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (mode_q) begin
				if (ge) begin
					x_q <= diff[64:0];
					acc_q <= (acc_q >> 1) + bit_q;
				end else begin
					acc_q <= acc_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				x_q <= ge ? diff[64:0] : xin;
				acc_q <= {acc_q[62:0], ge};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result = acc_q[31:0];

endmodule

[src/nearest_point_on_segments_search_unit.sv]
// Nearest point search over a stream of 3D segments. A projected segment
// takes multiply passes, a divide, a square root and sequencing states;
// one of zero length or measured at both endpoints skips the divide, and
// the latter takes a square root at each endpoint. The work is set by the
// single shared 34x34 multiplier and the shared bit-serial divide/square-root
// unit; a rejected segment skips both. An item that emits a result also
// passes the emit state, held while the previous result still waits in the
// output register. Stall stays high while an item is in work; a finished
// result waits in the output register while the next item is accepted.
module nearest_point_on_segments_search_unit import npss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_LEN, S_DOT, S_PICK, S_DIV, S_OFF, S_MAG, S_ROOT,
		S_UPD, S_FIN, S_EMIT
	} state_t;

	state_t state_q;
	logic [1:0] cnt_q;
	logic ends_q;
	logic second_q;
	logic last_q;

	logic signed [31:0] tg_q [3];
	logic signed [33:0] d_q [3];
	logic signed [33:0] dl_q [3];
	logic signed [33:0] v_q [3];
	logic signed [33:0] cand_q [3];
	logic [31:0] cand_dist_q;
	logic [7:0] lane_q;
	logic [7:0] key_q;
	logic [15:0] u_q;
	logic [63:0] len2_q;
	logic signed [67:0] acc_q;
	logic signed [67:0] prod_q;

	logic have_q;
	logic [20:0] best_dist_q;
	logic [7:0] best_lane_q;
	logic [7:0] best_key_q;
	logic signed [31:0] best_point_q [3];

	logic out_valid_q;
	out_item_t out_q;

	logic signed [33:0] ma;
	logic signed [33:0] mb;
	logic signed [67:0] acc_sum;
	logic signed [67:0] num;
	logic [20:0] dist_sat;
	logic in_range;
	logic box_ok;
	logic in_take;

	rd_req_t rd_req;
	rd_stat_t rd_stat;
	logic [63:0] rd_opa;
	logic [31:0] rd_res;

	assign in_take = in_valid & ~in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign acc_sum = acc_q + prod_q;
	assign num = -acc_sum;
	assign in_range = (32'(lane_q) < MAX_LANES) && (32'(key_q) < MAX_KEYS);
	assign dist_sat = (cand_dist_q > 32'(DIST_MAX)) ? DIST_MAX : cand_dist_q[20:0];

	always_comb begin
		box_ok = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (d_q[k] > BOX_LIMIT || d_q[k] < -BOX_LIMIT) begin
				box_ok = 1'b0;
			end
		end
	end

	// Select the operands of the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		if (cnt_q != 2'd3) begin
			case (state_q)
				S_LEN: begin
					ma = dl_q[cnt_q];
					mb = dl_q[cnt_q];
				end
				S_DOT: begin
					ma = d_q[cnt_q];
					mb = dl_q[cnt_q];
				end
				S_OFF: begin
					ma = dl_q[cnt_q];
					mb = {18'd0, u_q};
				end
				S_MAG: begin
					ma = v_q[cnt_q];
					mb = v_q[cnt_q];
				end
				default: begin
					ma = '0;
					mb = '0;
				end
			endcase
		end
	end

	// Requests to the divide / square-root unit
	always_comb begin
		rd_req.start = 1'b0;
		rd_req.sqrt_mode = 1'b0;
		rd_opa = '0;
		if (state_q == S_PICK && len2_q != 64'd0 && !acc_q[67]
				&& acc_q < $signed({4'd0, len2_q})) begin
			rd_req.start = 1'b1;
			rd_opa = acc_q[63:0];
		end else if (state_q == S_MAG && cnt_q == 2'd3) begin
			rd_req.start = 1'b1;
			rd_req.sqrt_mode = 1'b1;
			rd_opa = acc_sum[63:0];
		end
	end

	npss_root_div u_root_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(rd_req),
		.opa(rd_opa),
		.opb(len2_q),
		.stat(rd_stat),
		.result(rd_res)
	);

	// Target registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				tg_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET_X: tg_q[0] <= cfg_data;
				CFG_TARGET_Y: tg_q[1] <= cfg_data;
				CFG_TARGET_Z: tg_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, best match and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ends_q <= 1'b0;
			second_q <= 1'b0;
			last_q <= 1'b0;
			have_q <= 1'b0;
			best_dist_q <= '0;
			best_lane_q <= '0;
			best_key_q <= '0;
			for (int k = 0; k < 3; k++) begin
				best_point_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						last_q <= in_data.last_segment;
						if (in_data.first_segment) begin
							have_q <= 1'b0;
							best_dist_q <= '0;
							best_lane_q <= '0;
							best_key_q <= '0;
							for (int k = 0; k < 3; k++) begin
								best_point_q[k] <= '0;
							end
						end
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					cnt_q <= '0;
					state_q <= (in_range && box_ok) ? S_LEN : S_FIN;
				end
				S_LEN: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_DOT;
					end
				end
				S_DOT: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					second_q <= 1'b0;
					if (rd_req.start) begin
						ends_q <= 1'b0;
						state_q <= S_DIV;
					end else begin
						ends_q <= (len2_q != 64'd0);
						state_q <= S_MAG;
					end
				end
				S_DIV: begin
					if (rd_stat.done) begin
						state_q <= S_OFF;
					end
				end
				S_OFF: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (rd_stat.done) begin
						if (ends_q && !second_q) begin
							second_q <= 1'b1;
							state_q <= S_MAG;
						end else begin
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					if (!have_q || dist_sat < best_dist_q) begin
						have_q <= 1'b1;
						best_dist_q <= dist_sat;
						best_lane_q <= lane_q;
						best_key_q <= key_q;
						for (int k = 0; k < 3; k++) begin
							best_point_q[k] <= tg_q[k] + cand_q[k][31:0];
						end
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					lane_q <= in_data.lane_number;
					key_q <= in_data.key_number;
					d_q[0] <= 34'(in_data.seg_start_x) - 34'(tg_q[0]);
					d_q[1] <= 34'(in_data.seg_start_y) - 34'(tg_q[1]);
					d_q[2] <= 34'(in_data.seg_start_z) - 34'(tg_q[2]);
					dl_q[0] <= 34'(in_data.seg_delta_x);
					dl_q[1] <= 34'(in_data.seg_delta_y);
					dl_q[2] <= 34'(in_data.seg_delta_z);
				end
			end
			S_CHK: acc_q <= '0;
			S_LEN: begin
				if (cnt_q == 2'd3) begin
					len2_q <= acc_sum[63:0];
					acc_q <= '0;
				end else if (cnt_q != 2'd0) begin
					acc_q <= acc_sum;
				end
			end
			S_DOT: begin
				// keep the negated dot product
				if (cnt_q == 2'd3) begin
					acc_q <= num;
				end else if (cnt_q != 2'd0) begin
					acc_q <= acc_sum;
				end
			end
			S_PICK: begin
				acc_q <= '0;
				for (int k = 0; k < 3; k++) begin
					v_q[k] <= d_q[k];
				end
			end
			S_DIV: begin
				if (rd_stat.done) begin
					u_q <= rd_res[15:0];
				end
			end
			S_OFF: begin
				// point = start offset + floor(delta * u)
				if (cnt_q != 2'd0) begin
					v_q[cnt_q - 2'd1] <= d_q[cnt_q - 2'd1] + 34'(prod_q >>> 16);
				end
				acc_q <= '0;
			end
			S_MAG: begin
				if (cnt_q != 2'd0) begin
					acc_q <= acc_sum;
				end
			end
			S_ROOT: begin
				if (rd_stat.done) begin
					acc_q <= '0;
					if (!second_q || rd_res < cand_dist_q) begin
						cand_dist_q <= rd_res;
						for (int k = 0; k < 3; k++) begin
							cand_q[k] <= v_q[k];
						end
					end
					// second pass measures the far endpoint
					for (int k = 0; k < 3; k++) begin
						v_q[k] <= d_q[k] + dl_q[k];
					end
				end
			end
			S_EMIT: begin
				// load the result only once the output register is free
				if (!out_valid_q || !out_stall) begin
					out_q.found <= have_q;
					out_q.best_distance <= best_dist_q;
					out_q.best_lane <= best_lane_q;
					out_q.best_key <= best_key_q;
					out_q.near_x <= best_point_q[0];
					out_q.near_y <= best_point_q[1];
					out_q.near_z <= best_point_q[2];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef NO_ASSERTIONS
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("block took an item without going busy");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.found) |-> (out_data.best_distance == 21'd0
		&& out_data.best_lane == 8'd0 && out_data.best_key == 8'd0))
		else $error("result without a match carries nonzero fields");

	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_req.start |-> !rd_stat.busy)
		else $error("divide/root unit started while busy");
`endif

endmodule

[tb/sv/nearest_point_on_segments_search_unit_test.sv]
module nearest_point_on_segments_search_unit_test;
	import npss_pkg::*;

	localparam longint LIMIT_CYCLES = 2000000;
	localparam int SETTLE_CYCLES = 150;
	localparam longint BOX = 998400;

	// Track the best match per search and hold the expected search results
	class search_scoreboard;
		longint tgt[3];
		bit have_best;
		logic [20:0] best_dist;
		logic [7:0] best_lane;
		logic [7:0] best_key;
		logic [31:0] best_pt[3];
		out_item_t expected_results[$];
		int errors;

		function new();
			tgt = '{0, 0, 0};
			errors = 0;
			clear_best();
		endfunction

		function void clear_best();
			have_best = 0;
			best_dist = '0;
			best_lane = '0;
			best_key = '0;
			best_pt = '{0, 0, 0};
		endfunction

		function void set_target(cfg_index_t idx, logic [31:0] val);
			tgt[idx] = longint'($signed(val));
		endfunction

		static function bit [63:0] square(longint x);
			bit [63:0] a;
			a = (x < 0) ? 64'(-x) : 64'(x);
			return a * a;
		endfunction

		static function bit [63:0] floor_sqrt(bit [63:0] v);
			bit [63:0] res;
			bit [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// floor(num * 2^16 / den) for num < den
		static function longint ratio_q16(bit [63:0] num, bit [63:0] den);
			bit [64:0] rem;
			longint q;
			rem = num;
			q = 0;
			for (int i = 0; i < 16; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= {1'b0, den}) begin
					rem = rem - {1'b0, den};
					q = q | 1;
				end
			end
			return q;
		endfunction

		static function bit [63:0] length_of(longint v[3]);
			return floor_sqrt(square(v[0]) + square(v[1]) + square(v[2]));
		endfunction

		// Measure one segment against the target and keep it if strictly nearer
		function void measure(in_item_t it);
			longint d[3], dl[3], r[3], e[3];
			longint num, u;
			bit [63:0] len2, span, de;
			d[0] = longint'($signed(it.seg_start_x)) - tgt[0];
			d[1] = longint'($signed(it.seg_start_y)) - tgt[1];
			d[2] = longint'($signed(it.seg_start_z)) - tgt[2];
			dl[0] = longint'($signed(it.seg_delta_x));
			dl[1] = longint'($signed(it.seg_delta_y));
			dl[2] = longint'($signed(it.seg_delta_z));
			for (int k = 0; k < 3; k++) begin
				if (d[k] > BOX || d[k] < -BOX)
					return;
				r[k] = d[k];
			end
			len2 = square(dl[0]) + square(dl[1]) + square(dl[2]);
			if (len2 == 0) begin
				span = length_of(d);
			end else begin
				num = -(d[0] * dl[0] + d[1] * dl[1] + d[2] * dl[2]);
				if (num < 0 || 64'(num) >= len2) begin
					span = length_of(d);
					for (int k = 0; k < 3; k++)
						e[k] = d[k] + dl[k];
					de = length_of(e);
					if (de < span) begin
						span = de;
						r = e;
					end
				end else begin
					u = ratio_q16(num, len2);
					for (int k = 0; k < 3; k++)
						r[k] = d[k] + ((dl[k] * u) >>> 16);
					span = length_of(r);
				end
			end
			if (span > DIST_MAX)
				span = DIST_MAX;
			if (have_best && span >= best_dist)
				return;
			have_best = 1;
			best_dist = span[20:0];
			best_lane = it.lane_number;
			best_key = it.key_number;
			for (int k = 0; k < 3; k++)
				best_pt[k] = 32'(tgt[k] + r[k]);
		endfunction

		function void note_segment(in_item_t it);
			out_item_t res;
			if (it.first_segment)
				clear_best();
			if (it.lane_number < MAX_LANES && it.key_number < MAX_KEYS)
				measure(it);
			if (!it.last_segment)
				return;
			res = '0;
			if (have_best) begin
				res.found = 1;
				res.best_distance = best_dist;
				res.best_lane = best_lane;
				res.best_key = best_key;
				res.near_x = best_pt[0];
				res.near_y = best_pt[1];
				res.near_z = best_pt[2];
			end
			expected_results = {expected_results, res};
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.found !== exp_r.found || got.best_distance !== exp_r.best_distance ||
					got.best_lane !== exp_r.best_lane || got.best_key !== exp_r.best_key ||
					got.near_x !== exp_r.near_x || got.near_y !== exp_r.near_y ||
					got.near_z !== exp_r.near_z) begin
				$display("%0t: result mismatch expected %p actual %p", $time, exp_r, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	search_scoreboard sb;
	longint cycles;
	bit quiet;
	bit hold_req;
	bit hold_done;
	logic [31:0] tx, ty, tz;

	nearest_point_on_segments_search_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("nearest_point_on_segments_search_unit verification failed");
				$finish;
			end
		end
	end

	// Stall the result side in short bursts, once in a long stretch
	initial begin
		out_stall = 0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall = 1;
				repeat (600) @(negedge clk);
				out_stall = 0;
				hold_done = 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	task automatic write_target(cfg_index_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		sb.set_target(idx, val);
	endtask

	task automatic set_target(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		tx = x;
		ty = y;
		tz = z;
		write_target(CFG_TARGET_X, x);
		write_target(CFG_TARGET_Y, y);
		write_target(CFG_TARGET_Z, z);
	endtask

	// Offer one item, hold it until accepted
	task automatic send_segment(in_item_t it);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		sb.note_segment(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'd998400 : -32'sd998400;
			2: return $urandom_range(0, 1) ? 32'd998401 : -32'sd998401;
			3, 4: return 32'($signed($urandom_range(0, 8192)) - 4096);
			default: return 32'($signed($urandom_range(0, 1996800)) - 998400);
		endcase
	endfunction

	function automatic logic [31:0] pick_delta();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2: return $urandom;
			3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			4, 5: return 32'($signed($urandom_range(0, 8192)) - 4096);
			default: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
		endcase
	endfunction

	function automatic in_item_t make_segment(bit first, bit last);
		in_item_t it;
		logic [31:0] dz;
		dz = pick_delta();
		it.seg_start_x = tx + pick_offset();
		it.seg_start_y = ty + pick_offset();
		it.seg_start_z = tz + pick_offset();
		it.seg_delta_x = pick_delta();
		it.seg_delta_y = pick_delta();
		it.seg_delta_z = dz;
		if ($urandom_range(0, 7) == 0) begin
			it.seg_delta_x = 0;
			it.seg_delta_y = 0;
			it.seg_delta_z = 0;
		end
		it.lane_number = $urandom;
		it.key_number = $urandom;
		it.first_segment = first;
		it.last_segment = last;
		return it;
	endfunction

	function automatic in_item_t seg(int sx, int sy, int sz, int dx, int dy, int dz,
			logic [7:0] lane, logic [7:0] key, bit first, bit last);
		in_item_t it;
		it.seg_start_x = tx + sx;
		it.seg_start_y = ty + sy;
		it.seg_start_z = tz + sz;
		it.seg_delta_x = dx;
		it.seg_delta_y = dy;
		it.seg_delta_z = dz;
		it.lane_number = lane;
		it.key_number = key;
		it.first_segment = first;
		it.last_segment = last;
		return it;
	endfunction

	// Send one search: mostly well-formed, sometimes without a first or a last
	task automatic run_search(int len);
		bit first;
		bit last;
		for (int i = 0; i < len; i++) begin
			first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
			last = (i == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
			send_segment(make_segment(first, last));
		end
	endtask

	initial begin
		sb = new();
		quiet = 0;
		hold_req = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_TARGET_X;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		tx = 0;
		ty = 0;
		tz = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: before any target write, then around a plain target
		send_segment(seg(0, 0, 0, 0, 0, 0, 8'd0, 8'd0, 1'b0, 1'b1));
		drain();
		set_target(32'd1000, -32'sd2000, 32'd3000);
		// zero length, projection inside, endpoints, box edges
		send_segment(seg(500, 0, 0, 0, 0, 0, 8'd0, 8'd0, 1'b1, 1'b0));
		send_segment(seg(-1000, 256, 0, 2000, 0, 0, 8'd255, 8'd255, 1'b0, 1'b0));
		send_segment(seg(100, 100, 100, 500, 500, 500, 8'd3, 8'd4, 1'b0, 1'b0));
		send_segment(seg(-300, -10, 0, 100, 0, 0, 8'd5, 8'd6, 1'b0, 1'b1));
		send_segment(seg(998400, 0, 0, 0, 0, 0, 8'd1, 8'd1, 1'b1, 1'b1));
		send_segment(seg(998401, 0, 0, 0, 0, 0, 8'd1, 8'd1, 1'b1, 1'b1));
		send_segment(seg(0, -998401, 0, 5, 5, 5, 8'd1, 8'd1, 1'b1, 1'b1));
		// projections that fall inside the segment
		send_segment(seg(-50, 0, 0, 100, 0, 0, 8'd7, 8'd8, 1'b1, 1'b0));
		send_segment(seg(-50, 10, 0, 200, 0, 0, 8'd9, 8'd9, 1'b0, 1'b1));
		// equal distance does not replace
		send_segment(seg(40, 0, 0, 0, 0, 0, 8'd10, 8'd1, 1'b1, 1'b0));
		send_segment(seg(0, 40, 0, 0, 0, 0, 8'd11, 8'd2, 1'b0, 1'b1));
		// last without first, and a repeat emit
		send_segment(seg(3, 0, 0, 0, 0, 0, 8'd12, 8'd3, 1'b0, 1'b1));
		send_segment(seg(900000, 0, 0, 0, 0, 0, 8'd12, 8'd4, 1'b0, 1'b1));
		// extreme deltas
		send_segment(seg(-998400, 998400, -998400, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 8'd13, 8'd5, 1'b1, 1'b0));
		send_segment(seg(998400, -998400, 998400, 32'h80000000, 32'h80000000,
			32'h80000000, 8'd14, 8'd6, 1'b0, 1'b1));
		drain();

		// Wrap of the nearest point near the top of the range
		set_target(32'h7FFFFFFF, 32'h7FFFFF00, 32'h80000000);
		send_segment(seg(-100, 0, 0, 32'h7FFFFFFF, 0, 0, 8'd20, 8'd21, 1'b1, 1'b0));
		send_segment(seg(0, -10, 0, 0, 32'h7FFFFFFF, 0, 8'd22, 8'd23, 1'b0, 1'b1));
		send_segment(seg(10, 0, -10, 0, 0, 32'h80000000, 8'd24, 8'd25, 1'b1, 1'b1));
		send_segment(seg(0, 0, 0, 0, 0, 0, 8'd24, 8'd25, 1'b1, 1'b1));
		drain();

		// Random searches over several targets, extremes first
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_target(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
				1: set_target(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
				2: set_target(0, 0, 0);
				default: set_target($urandom, $urandom, $urandom);
			endcase
			if (ph == 3)
				hold_req = 1;
			if (ph == 7)
				quiet = 1;
			for (int n = 0; n < 80; ) begin
				int len;
				len = (ph == 3 && n < 30) ? 1 : $urandom_range(1, 8);
				run_search(len);
				n += len;
			end
			drain();
		end

		if (sb.expected_results.size() == 0 && sb.errors == 0)
			$display("nearest_point_on_segments_search_unit verification clean");
		else
			$display("nearest_point_on_segments_search_unit verification failed");
		$finish;
	end

endmodule
